@@ hw/rtl/c_subset_lexer_defines.svh @@
// Assertion macros shared by the c_subset_lexer RTL.
// Used inside modules that have clk and rst in scope; no other dependencies.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define CSL_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CSL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/csl_pkg.sv @@
// Package for the c_subset_lexer: token codes, scan modes, keyword table,
// queue entry types and default parameter values. No dependencies.
package csl_pkg;

  localparam int POS_BITS_DEF = 32;
  localparam int LEN_BITS_DEF = 16;
  localparam int KW_MAX_LEN_DEF = 8;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int N_KW = 12;

  localparam logic [5:0] K_END      = 6'd0;
  localparam logic [5:0] K_ERR      = 6'd1;
  localparam logic [5:0] K_INTC     = 6'd2;
  localparam logic [5:0] K_FLOATC   = 6'd3;
  localparam logic [5:0] K_LONGC    = 6'd4;
  localparam logic [5:0] K_UINTC    = 6'd5;
  localparam logic [5:0] K_ID       = 6'd6;
  localparam logic [5:0] K_KW0      = 6'd7;
  localparam logic [5:0] K_PLUS     = 6'd19;
  localparam logic [5:0] K_MINUS    = 6'd20;
  localparam logic [5:0] K_MUL      = 6'd21;
  localparam logic [5:0] K_DIV      = 6'd22;
  localparam logic [5:0] K_LPAREN   = 6'd23;
  localparam logic [5:0] K_RPAREN   = 6'd24;
  localparam logic [5:0] K_LBRACE   = 6'd25;
  localparam logic [5:0] K_RBRACE   = 6'd26;
  localparam logic [5:0] K_LBRACKET = 6'd27;
  localparam logic [5:0] K_RBRACKET = 6'd28;
  localparam logic [5:0] K_SEMI     = 6'd29;
  localparam logic [5:0] K_COMMA    = 6'd30;
  localparam logic [5:0] K_ASSIGN   = 6'd31;
  localparam logic [5:0] K_EQ       = 6'd32;
  localparam logic [5:0] K_NEQ      = 6'd33;
  localparam logic [5:0] K_LT       = 6'd34;
  localparam logic [5:0] K_LE       = 6'd35;
  localparam logic [5:0] K_GT       = 6'd36;
  localparam logic [5:0] K_GE       = 6'd37;
  localparam logic [5:0] K_STRING   = 6'd38;

  // keyword text, first character in the low byte
  localparam logic [63:0] KW_TEXT [N_KW] = '{
    64'("fi"), 64'("esle"), 64'("elihw"), 64'("od"), 64'("rof"), 64'("kaerb"),
    64'("nruter"), 64'("tni"), 64'("gnol"), 64'("taolf"), 64'("dengisnu"),
    64'("diov")
  };
  localparam logic [3:0] KW_LEN [N_KW] = '{
    4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd5, 4'd6, 4'd3, 4'd4, 4'd5, 4'd8, 4'd4
  };

  typedef enum logic [11:0] {
    M_IDLE    = 12'b000000000001,
    M_INT     = 12'b000000000010,
    M_FRAC    = 12'b000000000100,
    M_IDENT   = 12'b000000001000,
    M_SLASH   = 12'b000000010000,
    M_EQ      = 12'b000000100000,
    M_BANG    = 12'b000001000000,
    M_LT      = 12'b000010000000,
    M_GT      = 12'b000100000000,
    M_COMMENT = 12'b001000000000,
    M_STR     = 12'b010000000000,
    M_STR_ESC = 12'b100000000000
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hw/rtl/csl_front.sv @@
// Front end of the lexer: scan mode register and per-byte classification.
// Builds at most one queue entry of one or two tokens per item. Uses csl_pkg.
module csl_front
  import csl_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int LEN_BITS = LEN_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output logic       push,
  output entry_t     entry
);

  localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  mode_t                          mode, mode_next;
  logic [POS_BITS-1:0]            pos, pos_next;
  logic [POS_BITS-1:0]            lstart, lstart_next;
  logic [LEN_BITS-1:0]            llen, llen_next;
  logic [KEYWORD_MAX_LEN-1:0][7:0] lbuf, lbuf_next;

  logic [POS_BITS-1:0] pos_inc;
  logic [LEN_BITS-1:0] len_inc;
  logic                is_digit, is_alpha;

  logic                flush_v;
  logic [5:0]          flush_k, id_kind;
  logic [LEN_BITS-1:0] flush_l;

  mode_t      d_mode;
  logic       d_begin, d_emit;
  logic [5:0] d_kind;

  logic                e_v, mismatch, disp, has;
  logic [5:0]          e_k, k_cmp;
  logic [LEN_BITS-1:0] e_l;
  tok_t                tok_e, tok_d, tok_end;

  function automatic logic [31:0] sat_pos(input logic [POS_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [15:0] sat_len(input logic [LEN_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

  assign pos_inc  = (&pos) ? pos : pos + 1'b1;
  assign len_inc  = (&llen) ? llen : llen + 1'b1;
  assign is_digit = char_code inside {["0":"9"]};
  assign is_alpha = char_code inside {["a":"z"], ["A":"Z"], "_"};

  always_comb begin
    id_kind = K_ID;
    for (int i = N_KW - 1; i >= 0; i--) begin
      if (llen == LEN_BITS'(KW_LEN[i]) && lbuf[7:0] == KW_TEXT[i]) begin
        id_kind = 6'(K_KW0 + 6'(i));
      end
    end
  end

  always_comb begin
    flush_v = 1'b1;
    flush_k = K_ERR;
    flush_l = llen;
    case (mode)
      M_INT:   flush_k = K_INTC;
      M_FRAC:  flush_k = K_FLOATC;
      M_IDENT: flush_k = id_kind;
      M_SLASH: begin
        flush_k = K_DIV;
        flush_l = LEN_BITS'(1);
      end
      M_EQ: begin
        flush_k = K_ASSIGN;
        flush_l = LEN_BITS'(1);
      end
      M_BANG:  flush_l = LEN_BITS'(1);
      M_LT: begin
        flush_k = K_LT;
        flush_l = LEN_BITS'(1);
      end
      M_GT: begin
        flush_k = K_GT;
        flush_l = LEN_BITS'(1);
      end
      M_STR, M_STR_ESC: flush_k = K_ERR;
      default: flush_v = 1'b0;
    endcase
  end

  always_comb begin
    d_mode  = M_IDLE;
    d_begin = 1'b0;
    d_emit  = 1'b0;
    d_kind  = K_ERR;
    case (char_code)
      CH_SP, CH_LF, CH_CR, CH_TAB: ;
      "#": d_mode = M_COMMENT;
      "/": begin
        d_mode  = M_SLASH;
        d_begin = 1'b1;
      end
      "=": begin
        d_mode  = M_EQ;
        d_begin = 1'b1;
      end
      "!": begin
        d_mode  = M_BANG;
        d_begin = 1'b1;
      end
      "<": begin
        d_mode  = M_LT;
        d_begin = 1'b1;
      end
      ">": begin
        d_mode  = M_GT;
        d_begin = 1'b1;
      end
      "\"": begin
        d_mode  = M_STR;
        d_begin = 1'b1;
      end
      "+": begin d_emit = 1'b1; d_kind = K_PLUS;     end
      "-": begin d_emit = 1'b1; d_kind = K_MINUS;    end
      "*": begin d_emit = 1'b1; d_kind = K_MUL;      end
      "(": begin d_emit = 1'b1; d_kind = K_LPAREN;   end
      ")": begin d_emit = 1'b1; d_kind = K_RPAREN;   end
      "{": begin d_emit = 1'b1; d_kind = K_LBRACE;   end
      "}": begin d_emit = 1'b1; d_kind = K_RBRACE;   end
      "[": begin d_emit = 1'b1; d_kind = K_LBRACKET; end
      "]": begin d_emit = 1'b1; d_kind = K_RBRACKET; end
      ";": begin d_emit = 1'b1; d_kind = K_SEMI;     end
      ",": begin d_emit = 1'b1; d_kind = K_COMMA;    end
      default: begin
        if (is_digit) begin
          d_mode  = M_INT;
          d_begin = 1'b1;
        end else if (is_alpha) begin
          d_mode  = M_IDENT;
          d_begin = 1'b1;
        end else begin
          d_emit = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    lstart_next = lstart;
    llen_next   = llen;
    lbuf_next   = lbuf;
    e_v         = 1'b0;
    e_k         = K_ERR;
    e_l         = llen;
    mismatch    = 1'b0;
    disp        = 1'b0;
    k_cmp       = K_GE;
    if (end_of_input) begin
      e_v       = flush_v;
      e_k       = flush_k;
      e_l       = flush_l;
      mode_next = M_IDLE;
    end else begin
      pos_next = pos_inc;
      case (mode)
        M_IDLE: disp = 1'b1;
        M_COMMENT: begin
          if (char_code == CH_LF) mode_next = M_IDLE;
        end
        M_INT: begin
          if (is_digit) begin
            llen_next = len_inc;
          end else if (char_code == ".") begin
            llen_next = len_inc;
            mode_next = M_FRAC;
          end else if (char_code inside {"L", "l", "U", "u"}) begin
            llen_next = len_inc;
            e_v       = 1'b1;
            e_k       = (char_code inside {"L", "l"}) ? K_LONGC : K_UINTC;
            e_l       = len_inc;
            mode_next = M_IDLE;
          end else begin
            mismatch = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit) llen_next = len_inc;
          else mismatch = 1'b1;
        end
        M_IDENT: begin
          if (is_alpha || is_digit) begin
            if (32'(llen) < 32'(KEYWORD_MAX_LEN)) lbuf_next[llen[IDX_W-1:0]] = char_code;
            llen_next = len_inc;
          end else begin
            mismatch = 1'b1;
          end
        end
        M_SLASH: begin
          if (char_code == "/") mode_next = M_COMMENT;
          else mismatch = 1'b1;
        end
        M_EQ, M_BANG, M_LT, M_GT: begin
          case (mode)
            M_EQ:    k_cmp = K_EQ;
            M_BANG:  k_cmp = K_NEQ;
            M_LT:    k_cmp = K_LE;
            default: k_cmp = K_GE;
          endcase
          if (char_code == "=") begin
            e_v       = 1'b1;
            e_k       = k_cmp;
            e_l       = LEN_BITS'(2);
            mode_next = M_IDLE;
          end else begin
            mismatch = 1'b1;
          end
        end
        M_STR: begin
          llen_next = len_inc;
          if (char_code == "\"") begin
            e_v       = 1'b1;
            e_k       = K_STRING;
            e_l       = len_inc;
            mode_next = M_IDLE;
          end else if (char_code == "\\") begin
            mode_next = M_STR_ESC;
          end
        end
        M_STR_ESC: begin
          llen_next = len_inc;
          mode_next = M_STR;
        end
        default: disp = 1'b1;
      endcase
      if (mismatch) begin
        e_v  = flush_v;
        e_k  = flush_k;
        e_l  = flush_l;
        disp = 1'b1;
      end
      if (disp) begin
        mode_next = d_mode;
        if (d_begin) begin
          lstart_next = pos;
          llen_next   = LEN_BITS'(1);
          if (d_mode == M_IDENT) begin
            lbuf_next    = '0;
            lbuf_next[0] = char_code;
          end
        end
      end
    end
  end

  always_comb begin
    tok_e   = '{kind: e_k, start: sat_pos(lstart), len: sat_len(e_l)};
    tok_d   = '{kind: d_kind, start: sat_pos(pos), len: 16'd1};
    tok_end = '{kind: K_END, start: sat_pos(pos), len: 16'd0};
    if (end_of_input) begin
      has        = 1'b1;
      entry.two  = e_v;
      entry.tok0 = e_v ? tok_e : tok_end;
      entry.tok1 = tok_end;
    end else begin
      has        = e_v || (disp && d_emit);
      entry.two  = e_v && disp && d_emit;
      entry.tok0 = e_v ? tok_e : tok_d;
      entry.tok1 = tok_d;
    end
  end

  assign push = take && has;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      lstart <= '0;
      llen   <= '0;
      lbuf   <= '0;
    end else if (take) begin
      mode   <= mode_next;
      pos    <= pos_next;
      lstart <= lstart_next;
      llen   <= llen_next;
      lbuf   <= lbuf_next;
    end
  end

endmodule

@@ hw/rtl/csl_queue.sv @@
// Short token queue between the lexer front and back ends.
// Holds Q_DEPTH entries of one or two tokens. Uses csl_pkg and the defines header.
`include "c_subset_lexer_defines.svh"
module csl_queue
  import csl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  wr_entry,
  input  logic    pop,
  output entry_t  rd_entry,
  output q_stat_t stat
);

  entry_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= Q_PTR_W'((32'(wr_ptr) + 1) % Q_DEPTH);
      if (pop)  rd_ptr <= Q_PTR_W'((32'(rd_ptr) + 1) % Q_DEPTH);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CSL_ASSERT_IMPLY(a_no_overflow, push, !stat.full || pop, "push into full queue")
  `CSL_ASSERT_IMPLY(a_no_underflow, pop, !stat.empty, "pop from empty queue")

endmodule

@@ hw/rtl/csl_back.sv @@
// Back end of the lexer: drains queue entries into a registered token output,
// one token per transfer, and marks the last token of each item. Uses csl_pkg.
`include "c_subset_lexer_defines.svh"
module csl_back
  import csl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_stat_t     stat,
  input  entry_t      rd_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  logic pend_v;
  tok_t pend;
  logic load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend_v && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else if (load) begin
      if (pend_v) begin
        out_valid    <= 1'b1;
        pend_v       <= 1'b0;
        token_kind   <= pend.kind;
        token_start  <= pend.start;
        token_length <= pend.len;
        last_of_run  <= 1'b1;
      end else if (!stat.empty) begin
        out_valid    <= 1'b1;
        pend_v       <= rd_entry.two;
        pend         <= rd_entry.tok1;
        token_kind   <= rd_entry.tok0.kind;
        token_start  <= rd_entry.tok0.start;
        token_length <= rd_entry.tok0.len;
        last_of_run  <= !rd_entry.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  `CSL_ASSERT_IMPLY(a_pend_behind_first, pend_v, out_valid && !last_of_run,
                    "second token pending without first token on output")
  `CSL_ASSERT_NOW(a_pop_gated, !(pop && pend_v), "queue popped while second token pending")

endmodule

@@ hw/rtl/c_subset_lexer.sv @@
// c_subset_lexer: takes one byte or end marker per cycle while in_stall is low; the
// first token of an item is written into the queue, then registered onto the output,
// then one token per cycle while out_stall is low. Throughput: one item per cycle
// while the 4-entry queue has room; items that yield two tokens drain token by token.
// Reset (rst, synchronous): scan mode idle, offset zero, queue and output empty.
module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int LEN_BITS = LEN_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  logic    take, push, pop;
  entry_t  wr_entry, rd_entry;
  q_stat_t stat;

  assign in_stall = stat.full;
  assign take     = in_valid && !stat.full;

  csl_front #(
    .POS_BITS(POS_BITS),
    .LEN_BITS(LEN_BITS),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .char_code(char_code),
    .end_of_input(end_of_input),
    .push(push),
    .entry(wr_entry)
  );

  csl_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_entry(wr_entry),
    .pop(pop),
    .rd_entry(rd_entry),
    .stat(stat)
  );

  csl_back u_back (
    .clk(clk),
    .rst(rst),
    .stat(stat),
    .rd_entry(rd_entry),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .last_of_run(last_of_run)
  );

endmodule

@@ sim/tb_c_subset_lexer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for c_subset_lexer: byte and end-marker transfers in,
// tokens out, checked against an in-bench scanner model with random gaps on both sides.
// Depends on csl_pkg (token codes, scan modes) and the c_subset_lexer RTL.
module tb_c_subset_lexer;
  import csl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SRC_ITEMS = 1840;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } lex_tok_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       quiet;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  src_item_t pending_src[$];
  lex_tok_t  expected_toks[$];
  lex_tok_t  item_toks[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        free_left = 0;

  string kw_words [12] = '{"if", "else", "while", "do", "for", "break", "return",
                           "int", "long", "float", "unsigned", "void"};
  string op_words [20] = '{"+", "-", "*", "/", "(", ")", "{", "}", "[", "]", ";", ",",
                           "=", "==", "!=", "<", "<=", ">", ">=", "!"};
  logic [7:0] ws_bytes [4] = '{8'h20, 8'h0A, 8'h0D, 8'h09};

  // scanner model state
  mode_t       scan_st = M_IDLE;
  logic [31:0] lex_start = 32'd0;
  logic [15:0] lex_len = 16'd0;
  logic [31:0] byte_pos = 32'd0;
  logic [7:0]  id_buf [8] = '{default: 8'd0};

  c_subset_lexer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .end_of_input(end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .last_of_run(last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic [5:0] word_kind();
    bit hit;
    for (int i = 0; i < 12; i++) begin
      if (lex_len == 16'(kw_words[i].len())) begin
        hit = 1'b1;
        for (int j = 0; j < kw_words[i].len(); j++)
          if (id_buf[j] != kw_words[i][j]) hit = 1'b0;
        if (hit) return K_KW0 + 6'(i);
      end
    end
    return K_ID;
  endfunction

  task automatic emit_tok(input logic [5:0] kind, input logic [31:0] start,
                          input logic [15:0] len);
    lex_tok_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.last = 1'b0;
    item_toks.push_back(t);
  endtask

  task automatic grow_lexeme();
    if (lex_len != 16'hFFFF) lex_len = lex_len + 16'd1;
  endtask

  task automatic open_lexeme(input mode_t m, input logic [31:0] pos);
    scan_st = m;
    lex_start = pos;
    lex_len = 16'd1;
  endtask

  task automatic close_lexeme();
    case (scan_st)
      M_INT: emit_tok(K_INTC, lex_start, lex_len);
      M_FRAC: emit_tok(K_FLOATC, lex_start, lex_len);
      M_IDENT: emit_tok(word_kind(), lex_start, lex_len);
      M_SLASH: emit_tok(K_DIV, lex_start, 16'd1);
      M_EQ: emit_tok(K_ASSIGN, lex_start, 16'd1);
      M_BANG: emit_tok(K_ERR, lex_start, 16'd1);
      M_LT: emit_tok(K_LT, lex_start, 16'd1);
      M_GT: emit_tok(K_GT, lex_start, 16'd1);
      M_STR, M_STR_ESC: emit_tok(K_ERR, lex_start, lex_len);
      default: ;
    endcase
    scan_st = M_IDLE;
  endtask

  task automatic start_byte(input logic [7:0] b, input logic [31:0] pos);
    scan_st = M_IDLE;
    case (b)
      8'h20, 8'h0A, 8'h0D, 8'h09: ;
      "#": scan_st = M_COMMENT;
      "/": open_lexeme(M_SLASH, pos);
      "=": open_lexeme(M_EQ, pos);
      "!": open_lexeme(M_BANG, pos);
      "<": open_lexeme(M_LT, pos);
      ">": open_lexeme(M_GT, pos);
      "\"": open_lexeme(M_STR, pos);
      "+": emit_tok(K_PLUS, pos, 16'd1);
      "-": emit_tok(K_MINUS, pos, 16'd1);
      "*": emit_tok(K_MUL, pos, 16'd1);
      "(": emit_tok(K_LPAREN, pos, 16'd1);
      ")": emit_tok(K_RPAREN, pos, 16'd1);
      "{": emit_tok(K_LBRACE, pos, 16'd1);
      "}": emit_tok(K_RBRACE, pos, 16'd1);
      "[": emit_tok(K_LBRACKET, pos, 16'd1);
      "]": emit_tok(K_RBRACKET, pos, 16'd1);
      ";": emit_tok(K_SEMI, pos, 16'd1);
      ",": emit_tok(K_COMMA, pos, 16'd1);
      default: begin
        if (is_digit(b)) begin
          open_lexeme(M_INT, pos);
        end else if (is_alpha(b)) begin
          open_lexeme(M_IDENT, pos);
          id_buf = '{default: 8'd0};
          id_buf[0] = b;
        end else begin
          emit_tok(K_ERR, pos, 16'd1);
        end
      end
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic [31:0] pos);
    bit ends_lexeme;
    ends_lexeme = 1'b0;
    case (scan_st)
      M_IDLE: start_byte(b, pos);
      M_COMMENT: if (b == 8'h0A) scan_st = M_IDLE;
      M_INT: begin
        if (is_digit(b)) begin
          grow_lexeme();
        end else if (b == ".") begin
          grow_lexeme();
          scan_st = M_FRAC;
        end else if (b == "L" || b == "l" || b == "U" || b == "u") begin
          grow_lexeme();
          emit_tok((b == "L" || b == "l") ? K_LONGC : K_UINTC, lex_start, lex_len);
          scan_st = M_IDLE;
        end else begin
          ends_lexeme = 1'b1;
        end
      end
      M_FRAC: if (is_digit(b)) grow_lexeme(); else ends_lexeme = 1'b1;
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b)) begin
          if (lex_len < 16'd8) id_buf[lex_len[2:0]] = b;
          grow_lexeme();
        end else begin
          ends_lexeme = 1'b1;
        end
      end
      M_SLASH: if (b == "/") scan_st = M_COMMENT; else ends_lexeme = 1'b1;
      M_EQ, M_BANG, M_LT, M_GT: begin
        if (b == "=") begin
          emit_tok((scan_st == M_EQ) ? K_EQ : (scan_st == M_BANG) ? K_NEQ :
                   (scan_st == M_LT) ? K_LE : K_GE, lex_start, 16'd2);
          scan_st = M_IDLE;
        end else begin
          ends_lexeme = 1'b1;
        end
      end
      M_STR: begin
        grow_lexeme();
        if (b == "\"") begin
          emit_tok(K_STRING, lex_start, lex_len);
          scan_st = M_IDLE;
        end else if (b == "\\") begin
          scan_st = M_STR_ESC;
        end
      end
      M_STR_ESC: begin
        grow_lexeme();
        scan_st = M_STR;
      end
      default: start_byte(b, pos);
    endcase
    if (ends_lexeme) begin
      close_lexeme();
      start_byte(b, pos);
    end
  endtask

  // tokens produced by one accepted transfer
  task automatic lex_item(input logic [7:0] b, input logic eoi);
    lex_tok_t t;
    if (eoi) begin
      close_lexeme();
      emit_tok(K_END, byte_pos, 16'd0);
    end else begin
      scan_byte(b, byte_pos);
      if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    end
    if (item_toks.size() > 0) begin
      t = item_toks.pop_back();
      t.last = 1'b1;
      item_toks.push_back(t);
    end
    while (item_toks.size() > 0) expected_toks.push_back(item_toks.pop_front());
  endtask

  // stimulus helpers
  task automatic add_byte(input logic [7:0] c, input bit q);
    src_item_t it;
    it.ch = c;
    it.eoi = 1'b0;
    it.quiet = q;
    pending_src.push_back(it);
  endtask

  task automatic add_end(input bit q);
    src_item_t it;
    it.ch = 8'($urandom_range(0, 255));
    it.eoi = 1'b1;
    it.quiet = q;
    pending_src.push_back(it);
  endtask

  task automatic add_text(input string s, input bit q);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], q);
  endtask

  function automatic logic [7:0] name_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] suffix_char();
    string sfx;
    sfx = "LlUu";
    return sfx[$urandom_range(0, 3)];
  endfunction

  task automatic add_fragment();
    int sel;
    int n;
    int r;
    bit q;
    q = ($urandom_range(0, 4) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      add_text(kw_words[$urandom_range(0, 11)], q);
      if ($urandom_range(0, 3) == 0) add_byte(name_char(1'b0), q);
    end else if (sel < 28) begin
      n = $urandom_range(0, 11);
      add_byte(name_char(1'b1), q);
      repeat (n) add_byte(name_char(1'b0), q);
    end else if (sel < 42) begin
      n = $urandom_range(1, 5);
      repeat (n) add_byte(digit_char(), q);
      r = $urandom_range(0, 9);
      if (r < 3) begin
        add_byte(".", q);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(digit_char(), q);
        if ($urandom_range(0, 4) == 0) add_byte(suffix_char(), q);
      end else if (r < 6) begin
        add_byte(suffix_char(), q);
      end
    end else if (sel < 60) begin
      add_text(op_words[$urandom_range(0, 19)], q);
    end else if (sel < 68) begin
      add_byte("\"", q);
      n = $urandom_range(0, 8);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          add_byte("\\", q);
          add_byte(8'($urandom_range(0, 255)), q);
        end else if (r == 1) begin
          add_byte(8'($urandom_range(128, 255)), q);
        end else begin
          add_byte(8'($urandom_range(32, 126)), q);
        end
      end
      if ($urandom_range(0, 19) < 17) add_byte("\"", q);
    end else if (sel < 74) begin
      if ($urandom_range(0, 1) == 0) add_byte("#", q);
      else add_text("//", q);
      n = $urandom_range(0, 10);
      repeat (n) add_byte(8'($urandom_range(32, 126)), q);
      if ($urandom_range(0, 9) != 0) add_byte(8'h0A, q);
    end else if (sel < 80) begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte(ws_bytes[$urandom_range(0, 3)], q);
    end else if (sel < 93) begin
      add_byte(8'($urandom_range(0, 255)), q);
    end else begin
      add_end(q);
    end
    if ($urandom_range(0, 1) == 0) add_byte(ws_bytes[$urandom_range(0, 3)], q);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  always @(posedge clk) begin : drive
    src_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      char_code <= 8'd0;
      end_of_input <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) lex_item(char_code, end_of_input);
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_src.size() > 0) begin
        it = pending_src.pop_front();
        in_valid <= 1'b1;
        char_code <= it.ch;
        end_of_input <= it.eoi;
        gap_left = it.quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin : watch
    lex_tok_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      free_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_toks.size() == 0) begin
          $error("unexpected token transfer: kind %0d start %0d length %0d",
                 token_kind, token_start, token_length);
          mismatches++;
        end else begin
          want = expected_toks.pop_front();
          if (token_kind !== want.kind) begin
            $error("token_kind expected %0d actual %0d", want.kind, token_kind);
            mismatches++;
          end
          if (token_start !== want.start) begin
            $error("token_start expected %0d actual %0d", want.start, token_start);
            mismatches++;
          end
          if (token_length !== want.len) begin
            $error("token_length expected %0d actual %0d", want.len, token_length);
            mismatches++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, last_of_run);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else if (free_left != 0) begin
        out_stall <= 1'b0;
        free_left = free_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
        if ($urandom_range(0, 49) == 0) free_left = $urandom_range(40, 150);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // number suffix, dot then letter, lone slash, lone bang, invalid bytes,
    // pending compare at end, open string at end, comment at end
    add_text("7L3.u/x!", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte("<", 1'b0);
    add_end(1'b0);
    add_text("\"a\\\"", 1'b0);
    add_end(1'b0);
    add_text("//c", 1'b0);
    add_end(1'b0);

    while (pending_src.size() < SRC_ITEMS) add_fragment();
    add_end(1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_src.size() != 0 || in_valid || expected_toks.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_toks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/csl_pkg.sv
hw/rtl/csl_front.sv
hw/rtl/csl_queue.sv
hw/rtl/csl_back.sv
hw/rtl/c_subset_lexer.sv
sim/tb_c_subset_lexer.sv
